// ===== src/coam_pkg.sv =====
`timescale 1ns / 1ps
package coam_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd4;

  // Processing modes
  localparam logic [2:0] MODE_DIRECT   = 3'd0;
  localparam logic [2:0] MODE_SOFTMAX  = 3'd1;
  localparam logic [2:0] MODE_SOFT_SCL = 3'd2;
  localparam logic [2:0] MODE_LOGITS   = 3'd3;
  localparam logic [2:0] MODE_EXPER    = 3'd4;

  // log2(e) and 0.1*log2(e) in Q16
  localparam logic [16:0] LOG2E_Q16       = 17'd94548;
  localparam logic [16:0] LOG2E_TENTH_Q16 = 17'd9455;
  // ln2 in Q32 for the table series
  localparam logic [63:0] LN2_Q32         = 64'd2977044472;
  localparam int          SERIES_TERMS    = 14;

  // Dividend width of the shared divider (2^32 needs 33 bits)
  localparam int DVD_W = 33;

  // Sequencer states
  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_RD    = 6'b000010,
    S_MUL   = 6'b000100,
    S_ACC   = 6'b001000,
    S_DINIT = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

endpackage

// ===== src/classifier_output_argmax_softmax_top.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tdata: logit_code[15:0]; tlast: last
// out_    | out | out_tvalid/tready  | tdata: class_index, reading_value, confidence
// cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
// Loading takes one item per cycle while idle in the load state. The item marked
// last starts a sequencer: softmax modes walk the stored logits through the exp
// unit one by one (memory read, multiply, table and accumulate), then the shared
// divider runs two divisions (reading value, confidence).
// Reset (rst_n, synchronous) clears control state and loads register defaults.
// The result waits in an output register; a stalled output holds the
// sequencer only at its final step.
module classifier_output_argmax_softmax_top #(
  parameter int MAX_CLASSES     = 128,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [15:0] logit_code
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] class_index, [21:7] reading_value, [53:22] confidence, [55:54] zero
  output logic [55:0]                      out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [coam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [coam_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import coam_pkg::*;

  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int SUM_W = 17 + IDX_W;
  localparam int TBL_W = $clog2(EXP_TABLE_DEPTH);

  // Table entry 2^(-k/depth) in Q1.16 from an integer series
  function automatic logic [16:0] exp_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [65:0] acc;
    logic [63:0]        res;
    x    = (64'(k) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
    term = 64'd1 << 32;
    acc  = 66'(term);
    for (int n = 1; n < SERIES_TERMS; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2 == 1) acc = acc - 66'(term);
      else            acc = acc + 66'(term);
    end
    if (acc < 0) acc = '0;
    res = (acc[63:0] + 64'd32768) >> 16;
    return res[16:0];
  endfunction

  logic [16:0] exp_tbl [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tbl
    assign exp_tbl[g] = exp_entry(g);
  end

  // Configuration registers
  logic [2:0]  mode_r;
  logic [7:0]  divisor_r;
  logic        quant_r;
  logic [7:0]  zp_r;
  logic [15:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DIRECT;
      divisor_r <= 8'd10;
      quant_r   <= 1'b1;
      zp_r      <= 8'd0;
      scale_r   <= 16'd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:    mode_r    <= cfg_wdata[2:0];
        REG_DIVISOR: divisor_r <= cfg_wdata[7:0];
        REG_QUANT:   quant_r   <= cfg_wdata[0];
        REG_ZP:      zp_r      <= cfg_wdata[7:0];
        REG_SCALE:   scale_r   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Mode decode
  logic is_soft, is_tenth, is_scaled, is_logits;
  assign is_tenth  = (mode_r == MODE_EXPER);
  assign is_soft   = (mode_r == MODE_SOFTMAX) || (mode_r == MODE_SOFT_SCL) || is_tenth;
  assign is_logits = (mode_r == MODE_LOGITS);
  assign is_scaled = (mode_r == MODE_SOFT_SCL) || is_logits || is_tenth;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r;
  logic signed [15:0]      max_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        rd_addr_r;
  logic signed [15:0]      rd_data_r;
  logic [32:0]             prod_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        rem_r;
  logic [DVD_W-1:0]        quo_r;
  logic [5:0]              step_r;
  logic                    phase_r;
  logic [14:0]             reading_r;
  logic                    out_valid_r;
  logic [55:0]             out_data_r;
  logic signed [15:0]      store [MAX_CLASSES];

  // Dequantize and saturate the incoming element
  logic signed [9:0]  code_diff;
  logic signed [26:0] dq_prod;
  logic signed [15:0] dq_sat;
  logic signed [15:0] elem;
  logic               in_acc;
  logic               room;

  assign code_diff = $signed({2'b00, in_tdata[7:0]}) - $signed({2'b00, zp_r});
  assign dq_prod   = 27'(code_diff) * $signed({11'd0, scale_r});
  always_comb begin
    if (dq_prod > 27'sd32767)       dq_sat = 16'sh7fff;
    else if (dq_prod < -27'sd32768) dq_sat = 16'sh8000;
    else                            dq_sat = dq_prod[15:0];
  end
  assign elem    = quant_r ? dq_sat : $signed(in_tdata);
  assign in_acc  = in_tvalid && in_tready;
  assign room    = (cnt_r < CNT_W'(MAX_CLASSES));
  assign in_tready = (state_r == S_LOAD);

  // Exp unit: table lookup and shift on the registered product
  logic [33:0]        b_sum;
  logic [25:0]        b_val;
  logic [31:0]        ti_prod;
  logic [TBL_W-1:0]   ti;
  logic [16:0]        e_val;
  logic signed [16:0] diff;
  logic [16:0]        k_sel;

  assign diff    = 17'(max_r) - 17'(rd_data_r);
  assign k_sel   = is_tenth ? LOG2E_TENTH_Q16 : LOG2E_Q16;
  assign b_sum   = 34'(prod_r) + 34'd128;
  assign b_val   = b_sum[33:8];
  assign ti_prod = 32'(b_val[15:0]) * 32'(EXP_TABLE_DEPTH);
  assign ti      = ti_prod[16 +: TBL_W];
  assign e_val   = (b_val[25:16] >= 10'd32) ? 17'd0 : (exp_tbl[ti] >> b_val[20:16]);

  // Shared restoring divider step
  logic [SUM_W:0]   rem_sh;
  logic [SUM_W:0]   dvsr;
  logic             qbit;
  logic [SUM_W:0]   rem_sub;
  logic [DVD_W-1:0] q_fin;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign dvsr    = phase_r ? {1'b0, sum_r} : (SUM_W+1)'(divisor_r);
  assign qbit    = (rem_sh >= dvsr);
  assign rem_sub = qbit ? (rem_sh - dvsr) : rem_sh;
  assign q_fin   = {quo_r[DVD_W-2:0], qbit};

  logic out_free;
  logic publish;
  assign out_free = !out_valid_r || out_tready;
  assign publish  = (state_r == S_DIV) && phase_r && (step_r == 6'(DVD_W - 1)) && out_free;

  // Confidence and reading from the final quotient
  logic [31:0] conf_val;
  logic [14:0] read_val;
  always_comb begin
    if (is_soft) begin
      if (sum_r == '0 || q_fin[32] || q_fin[31]) conf_val = 32'h7fff_ffff;
      else                                       conf_val = q_fin[31:0];
    end else if (is_logits) begin
      conf_val = 32'h0001_0000;
    end else begin
      conf_val = {{8{max_r[15]}}, max_r, 8'd0};
    end
    if (is_scaled) begin
      if (divisor_r == 8'd0 || (|q_fin[32:15])) read_val = 15'h7fff;
      else                                      read_val = q_fin[14:0];
    end else begin
      read_val = 15'(idx_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (in_acc && in_tlast) state_nxt = is_soft ? S_RD : S_DINIT;
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = (CNT_W'(rd_addr_r) + 1'b1 == cnt_r) ? S_DINIT : S_RD;
      S_DINIT: state_nxt = S_DIV;
      S_DIV:   if (step_r == 6'(DVD_W - 1)) begin
        if (!phase_r)      state_nxt = S_DINIT;
        else if (out_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Store write and read port
  always_ff @(posedge clk) begin
    if (in_acc && room) store[cnt_r[IDX_W-1:0]] <= elem;
    rd_data_r <= store[rd_addr_r];
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      max_r       <= '0;
      idx_r       <= '0;
      rd_addr_r   <= '0;
      sum_r       <= '0;
      phase_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && !publish) out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          // Store the element and track the first maximum
          if (in_acc && room) begin
            if (cnt_r == '0 || elem > max_r) begin
              max_r <= elem;
              idx_r <= cnt_r[IDX_W-1:0];
            end
            cnt_r <= cnt_r + 1'b1;
          end
          if (in_acc && in_tlast) begin
            rd_addr_r <= '0;
            sum_r     <= '0;
            phase_r   <= 1'b0;
          end
        end
        S_MUL: prod_r <= 33'(diff[15:0]) * 33'(k_sel);
        S_ACC: begin
          sum_r     <= sum_r + SUM_W'(e_val);
          rd_addr_r <= rd_addr_r + 1'b1;
        end
        S_DINIT: begin
          rem_r  <= '0;
          step_r <= '0;
          quo_r  <= phase_r ? (DVD_W'(1) << 32) : DVD_W'({idx_r, 8'd0});
        end
        S_DIV: begin
          if (step_r != 6'(DVD_W - 1)) begin
            rem_r  <= rem_sub[SUM_W-1:0];
            quo_r  <= q_fin;
            step_r <= step_r + 1'b1;
          end else if (!phase_r) begin
            reading_r <= read_val;
            phase_r   <= 1'b1;
          end else if (out_free) begin
            // Publish the result and start a new vector
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, conf_val, reading_r, 7'(idx_r)};
            cnt_r       <= '0;
            max_r       <= '0;
            idx_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CLASSES))
    else $error("element count beyond capacity");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input taken while a vector is being finished");

  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (CNT_W'(rd_addr_r) < cnt_r))
    else $error("exp walk past stored elements");

  a_out_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && phase_r && step_r == 6'(DVD_W - 1) && out_valid_r && !out_tready)
    |=> (state_r == S_DIV))
    else $error("result dropped while output stalled");

endmodule
